// ===== rtl/rksj_pkg.sv =====
`timescale 1ns / 1ps
package rksj_pkg;

  localparam logic [15:0] KEY_TEST   = 16'h322C;
  localparam logic [15:0] KEY_FUNC   = 16'h3254;
  localparam logic [15:0] KEY_OK     = 16'h325C;
  localparam logic [15:0] KEY_CMD    = 16'h32C9;
  localparam logic [15:0] KEY_BACK   = 16'h325E;
  localparam logic [15:0] KEY_RESET  = 16'h320C;
  localparam logic [15:0] KEY_UP     = 16'h3258;
  localparam logic [15:0] KEY_DOWN   = 16'h3259;
  localparam logic [15:0] KEY_REC    = 16'h32F3;
  localparam logic [15:0] KEY_DIGIT0 = 16'h3200;

  localparam logic [3:0] DIGIT_EMPTY = 4'hF;

  // position every servo holds after reset
  localparam logic [11:0] HOME_RESET = 12'd280;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic [1:0] REG_HOME = 2'd3;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_UP     = 2'd1,
    OP_DOWN   = 2'd2,
    OP_REC    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

  // classified job handed from front to back, with status snapshot
  typedef struct packed {
    op_e          op;
    logic         move_mode;
    logic         entry_active;
    logic [31:0]  enable_mask;
    logic [31:0]  direction_mask;
    logic [7:0]   valve_mask;
    logic [13:0]  command_number;
  } job_t;

  function automatic logic [23:0] group_mask(input logic [4:0] g);
    logic [23:0] m;
    begin
      unique case (g)
        5'd0:  m = 24'h00003F;
        5'd1:  m = 24'h000FC0;
        5'd2:  m = 24'h03F000;
        5'd3:  m = 24'hFC0000;
        5'd4:  m = 24'h000021;
        5'd5:  m = 24'h000012;
        5'd6:  m = 24'h00000C;
        5'd7:  m = 24'h000038;
        5'd8:  m = 24'h000007;
        5'd9:  m = 24'h000840;
        5'd10: m = 24'h000480;
        5'd11: m = 24'h000300;
        5'd12: m = 24'h000E00;
        5'd13: m = 24'h0001C0;
        5'd14: m = 24'h021000;
        5'd15: m = 24'h012000;
        5'd16: m = 24'h00C000;
        5'd17: m = 24'h038000;
        5'd18: m = 24'h007000;
        5'd19: m = 24'h840000;
        5'd20: m = 24'h480000;
        5'd21: m = 24'h300000;
        5'd22: m = 24'hE00000;
        5'd23: m = 24'h1C0000;
        default: m = 24'h000000;
      endcase
      return m;
    end
  endfunction

endpackage

// ===== rtl/rksj_front.sv =====
`timescale 1ns / 1ps
module rksj_front
  import rksj_pkg::*;
#(
  parameter int NUM_SERVOS = 24,
  parameter int NUM_VALVES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [16:0] ir_code_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  localparam logic [31:0] SERVO_ALL = 32'hFFFF_FFFF >> (32 - NUM_SERVOS);
  localparam logic [7:0]  VALVE_ALL = 8'hFF >> (8 - NUM_VALVES);

  logic        mode_q, mode_d;
  logic        entry_q, entry_d;
  logic [3:0]  dig_q [4];
  logic [3:0]  dig_d [4];
  logic [31:0] en_q, en_d, dir_q, dir_d;
  logic [7:0]  valve_q, valve_d;
  logic        busy_q, busy_d;
  job_t        job_q, job_d;

  logic [15:0] key;
  logic [13:0] number;
  logic [13:0] nm1;
  logic [4:0]  sidx;
  logic [3:0]  vidx;
  logic [4:0]  gidx;
  logic        take;
  op_e         op;

  assign key        = ir_code_i[15:0];
  assign in_ready_o = !busy_q;
  assign take       = in_valid_i && !busy_q;
  assign job_valid_o = busy_q;
  assign job_o      = job_q;

  // decoded number: digits until first empty slot
  always_comb begin
    logic stop;
    stop   = 1'b0;
    number = '0;
    if (dig_q[0] == DIGIT_EMPTY) stop = 1'b1;
    else number = number + 14'(dig_q[0]) * 14'd1000;
    if (!stop && dig_q[1] != DIGIT_EMPTY) number = number + 14'(dig_q[1]) * 14'd100;
    else stop = 1'b1;
    if (!stop && dig_q[2] != DIGIT_EMPTY) number = number + 14'(dig_q[2]) * 14'd10;
    else stop = 1'b1;
    if (!stop && dig_q[3] != DIGIT_EMPTY) number = number + 14'(dig_q[3]);
  end

  assign nm1  = number - 14'd1;
  assign sidx = nm1[6:2];
  assign vidx = 4'((number - 14'd500) >> 1);
  assign gidx = 5'(number - 14'd600);

  always_comb begin
    mode_d  = mode_q;
    entry_d = entry_q;
    dig_d   = dig_q;
    en_d    = en_q;
    dir_d   = dir_q;
    valve_d = valve_q;
    busy_d  = busy_q;
    job_d   = job_q;
    op      = OP_STATUS;
    if (busy_q && job_ready_i) busy_d = 1'b0;
    if (take) begin
      job_d.command_number = '0;
      if (key == KEY_TEST) begin
      end else if (key == KEY_FUNC) begin
        mode_d = !mode_q;
      end else if (mode_q) begin
        if (key == KEY_UP) op = OP_UP;
        else if (key == KEY_DOWN) op = OP_DOWN;
        else if (key == KEY_REC) op = OP_REC;
      end else if (!entry_q) begin
        if (key == KEY_RESET) begin
          mode_d  = 1'b0;
          entry_d = 1'b0;
          for (int i = 0; i < 4; i++) dig_d[i] = DIGIT_EMPTY;
          en_d    = '0;
          dir_d   = '0;
          valve_d = '0;
        end else if (key == KEY_CMD) begin
          entry_d = 1'b1;
        end
      end else begin
        if (key == KEY_OK) begin
          job_d.command_number = number;
          if (number >= 14'd1 && number <= 14'd96) begin
            if (32'(sidx) < NUM_SERVOS) begin
              unique case (nm1[1:0])
                2'd0: en_d[sidx]  = 1'b1;
                2'd1: en_d[sidx]  = 1'b0;
                2'd2: dir_d[sidx] = 1'b0;
                default: dir_d[sidx] = 1'b1;
              endcase
            end
          end else if (number >= 14'd500 && number <= 14'd513) begin
            if (32'(vidx) < NUM_VALVES) valve_d[vidx[2:0]] = !number[0];
          end else if (number >= 14'd600 && number <= 14'd623) begin
            en_d = {8'h00, group_mask(gidx)} & SERVO_ALL;
          end
          for (int i = 0; i < 4; i++) dig_d[i] = DIGIT_EMPTY;
          entry_d = 1'b0;
        end else if (key == KEY_BACK) begin
          for (int i = 0; i < 4; i++) dig_d[i] = DIGIT_EMPTY;
          entry_d = 1'b0;
        end else if (key >= KEY_DIGIT0 && key <= KEY_DIGIT0 + 16'd9) begin
          if (dig_q[0] == DIGIT_EMPTY) dig_d[0] = key[3:0];
          else if (dig_q[1] == DIGIT_EMPTY) dig_d[1] = key[3:0];
          else if (dig_q[2] == DIGIT_EMPTY) dig_d[2] = key[3:0];
          else if (dig_q[3] == DIGIT_EMPTY) dig_d[3] = key[3:0];
        end
      end
      busy_d               = 1'b1;
      job_d.op             = op;
      job_d.move_mode      = mode_d;
      job_d.entry_active   = entry_d;
      job_d.enable_mask    = en_d & SERVO_ALL;
      job_d.direction_mask = dir_d & SERVO_ALL;
      job_d.valve_mask     = valve_d & VALVE_ALL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      entry_q <= 1'b0;
      for (int i = 0; i < 4; i++) dig_q[i] <= DIGIT_EMPTY;
      en_q    <= '0;
      dir_q   <= '0;
      valve_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      entry_q <= entry_d;
      dig_q   <= dig_d;
      en_q    <= en_d;
      dir_q   <= dir_d;
      valve_q <= valve_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ===== rtl/rksj_back.sv =====
`timescale 1ns / 1ps
module rksj_back
  import rksj_pkg::*;
#(
  parameter int NUM_SERVOS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [11:0] min_pos_i,
  input  logic [11:0] max_pos_i,
  input  logic [7:0]  step_i,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [4:0]  channel_o,
  output logic [11:0] position_o,
  output logic        at_limit_o,
  output logic        move_mode_o,
  output logic        entry_active_o,
  output logic [23:0] enable_mask_o,
  output logic [23:0] direction_mask_o,
  output logic [6:0]  valve_mask_o,
  output logic [13:0] command_number_o,
  output logic        last_o
);

  localparam int IW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SERVOS - 1);

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [NUM_SERVOS-1:0] valid_q;
  logic [11:0] pos_mem [NUM_SERVOS];
  logic [11:0] rd_q;
  logic        rd_valid_q;
  logic [IW-1:0] rd_idx_q;
  logic        rd_last_q;
  logic        pend_q;

  logic        sel;
  logic        any_sel;
  logic        later_sel;
  logic [11:0] cur;
  logic signed [13:0] np;
  logic        lim;
  logic        wr;
  logic        load;
  logic        ovalid_q;
  logic        oslot_free;
  logic        rd_go;

  logic [NUM_SERVOS-1:0] en_v, dir_v;
  assign en_v  = job_q.enable_mask[NUM_SERVOS-1:0];
  assign dir_v = job_q.direction_mask[NUM_SERVOS-1:0];

  always_comb begin
    later_sel = 1'b0;
    for (int i = 0; i < NUM_SERVOS; i++)
      if (IW'(i) > idx_q && (job_q.op == OP_REC || en_v[i])) later_sel = 1'b1;
  end

  assign any_sel = |en_v;
  assign sel = (job_q.op == OP_REC) || en_v[idx_q];
  assign oslot_free = !ovalid_q || out_ready_i;
  assign job_ready_o = (state_q == ST_IDLE);
  assign load = job_valid_i && job_ready_o;
  // a read is issued in walk state only if the registered read slot is free and the entry is selected
  assign rd_go = (state_q == ST_WALK) && !pend_q && sel;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: if (load) begin
        idx_d = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (job_q.op == OP_STATUS || (job_q.op != OP_REC && !any_sel)) begin
          if (oslot_free) state_d = ST_IDLE;
        end else state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!pend_q || rd_valid_q) begin
          if (!pend_q) begin
            if (idx_q == LAST_IDX || (!sel && !later_sel) ||
                (sel && !later_sel)) begin
              if (!sel) state_d = ST_IDLE;
            end else if (!sel) idx_d = idx_q + 1'b1;
          end
        end
        if (rd_valid_q && oslot_free) begin
          if (rd_last_q) state_d = ST_IDLE;
          else idx_d = rd_idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // entries not written since reset still hold the reset home position
  assign cur = valid_q[rd_idx_q] ? rd_q : HOME_RESET;
  always_comb begin
    logic signed [13:0] d;
    d = 14'(step_i);
    if ((job_q.op == OP_DOWN) ^ dir_v[rd_idx_q]) d = -d;
    np = $signed({2'b00, cur}) + d;
  end
  assign lim = (job_q.op != OP_REC) &&
               !(np >= $signed({2'b00, min_pos_i}) && np <= $signed({2'b00, max_pos_i}));
  assign wr  = rd_valid_q && oslot_free && (job_q.op != OP_REC) && !lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      valid_q    <= '0;
      pend_q     <= 1'b0;
      rd_valid_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (wr) valid_q[rd_idx_q] <= 1'b1;
      if (rd_go) begin
        pend_q     <= 1'b1;
        rd_valid_q <= 1'b1;
      end else if (rd_valid_q && oslot_free) begin
        pend_q     <= 1'b0;
        rd_valid_q <= 1'b0;
      end
      if (oslot_free)
        ovalid_q <= (rd_valid_q) ||
                    (state_q == ST_EMIT &&
                     (job_q.op == OP_STATUS || (job_q.op != OP_REC && !any_sel)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_i;
    if (rd_go) begin
      rd_q      <= pos_mem[idx_q];
      rd_idx_q  <= idx_q;
      rd_last_q <= (idx_q == LAST_IDX) || !later_sel;
    end
    if (wr) pos_mem[rd_idx_q] <= np[11:0];
    if (oslot_free) begin
      move_mode_o      <= job_q.move_mode;
      entry_active_o   <= job_q.entry_active;
      enable_mask_o    <= job_q.enable_mask[23:0];
      direction_mask_o <= job_q.direction_mask[23:0];
      valve_mask_o     <= job_q.valve_mask[6:0];
      if (rd_valid_q) begin
        kind_o           <= 1'b1;
        channel_o        <= 5'(rd_idx_q);
        position_o       <= lim || job_q.op == OP_REC ? cur : np[11:0];
        at_limit_o       <= lim;
        command_number_o <= '0;
        last_o           <= rd_last_q;
      end else begin
        kind_o           <= 1'b0;
        channel_o        <= '0;
        position_o       <= '0;
        at_limit_o       <= 1'b0;
        command_number_o <= job_q.command_number;
        last_o           <= 1'b1;
      end
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// ===== rtl/remote_keyed_servo_jog_controller_unit.sv =====
`timescale 1ns / 1ps
// Remote-keyed servo jog controller. A front stage decodes each key, updates
// mode, digit entry, enable/direction masks and valves, and hands a job to
// the back stage through a one-entry holding register. The back stage emits
// one status item, or walks the servo position store in index order and
// emits one position item per selected servo. Each selected entry is read,
// then output and, for up/down within the limits, written back; skipped
// entries are stepped past, and the walk stops after the last selected servo.
// The output can be held by out_ready_i. The front accepts the next key while
// the back stage is still busy. All servos hold 280 after reset; writing
// home_position later does not move them.
module remote_keyed_servo_jog_controller_unit
  import rksj_pkg::*;
#(
  parameter int NUM_SERVOS = 24,
  parameter int NUM_VALVES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [16:0] ir_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [4:0]  channel_o,
  output logic [11:0] position_o,
  output logic        at_limit_o,
  output logic        move_mode_o,
  output logic        entry_active_o,
  output logic [23:0] enable_mask_o,
  output logic [23:0] direction_mask_o,
  output logic [6:0]  valve_mask_o,
  output logic [13:0] command_number_o,
  output logic        last_o
);

  logic [11:0] min_q, max_q;
  logic [7:0]  step_q;
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= 12'd95;
      max_q  <= 12'd460;
      step_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN:  min_q  <= cfg_data_i;
        REG_MAX:  max_q  <= cfg_data_i;
        REG_STEP: step_q <= cfg_data_i[7:0];
        REG_HOME: ;
      endcase
    end
  end

  rksj_front #(.NUM_SERVOS(NUM_SERVOS), .NUM_VALVES(NUM_VALVES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .ir_code_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rksj_back #(.NUM_SERVOS(NUM_SERVOS)) u_back (
    .clk_i, .rst_ni,
    .min_pos_i(min_q), .max_pos_i(max_q), .step_i(step_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o, .out_ready_i, .kind_o, .channel_o, .position_o, .at_limit_o,
    .move_mode_o, .entry_active_o, .enable_mask_o, .direction_mask_o,
    .valve_mask_o, .command_number_o, .last_o
  );

endmodule

// ===== test/remote_keyed_servo_jog_controller_unit_test.sv =====
`timescale 1ns / 1ps
module remote_keyed_servo_jog_controller_unit_test;
  import rksj_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [4:0]  channel;
    logic [11:0] position;
    logic        at_limit;
    logic        move_mode;
    logic        entry_active;
    logic [23:0] enable_mask;
    logic [23:0] direction_mask;
    logic [6:0]  valve_mask;
    logic [13:0] command_number;
    logic        last;
  } servo_result_t;

  class jog_predictor;
    servo_result_t expected_results[$];
    int mismatches;
    int results_seen;
    logic [11:0] min_pos, max_pos, home_pos;
    logic [7:0]  step;
    logic        move_mode, entry;
    logic [3:0]  digits[4];
    logic [23:0] enables, dirs;
    logic [6:0]  valves;
    logic [11:0] pos[24];

    function new();
      min_pos = 95;
      max_pos = 460;
      step = 5;
      home_pos = 280;
      clear_settings();
      for (int i = 0; i < 24; i++) pos[i] = home_pos;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void clear_settings();
      move_mode = 0;
      entry = 0;
      for (int i = 0; i < 4; i++) digits[i] = DIGIT_EMPTY;
      enables = '0;
      dirs = '0;
      valves = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] v);
      case (idx)
        REG_MIN:  min_pos = v;
        REG_MAX:  max_pos = v;
        REG_STEP: step = v[7:0];
        REG_HOME: home_pos = v;
        default: ;
      endcase
    endfunction

    function void push(logic k, logic [4:0] ch, logic [11:0] p, logic lim, logic [13:0] cmd);
      servo_result_t r;
      r.kind = k;
      r.channel = ch;
      r.position = p;
      r.at_limit = lim;
      r.move_mode = move_mode;
      r.entry_active = entry;
      r.enable_mask = enables;
      r.direction_mask = dirs;
      r.valve_mask = valves;
      r.command_number = cmd;
      r.last = 0;
      expected_results.push_back(r);
    endfunction

    function void run_number(int n);
      int idx;
      if (n >= 1 && n <= 96) begin
        idx = (n - 1) / 4;
        case ((n - 1) % 4)
          0: enables[idx] = 1;
          1: enables[idx] = 0;
          2: dirs[idx] = 0;
          default: dirs[idx] = 1;
        endcase
      end else if (n >= 500 && n <= 513) begin
        idx = (n - 500) / 2;
        if (idx < 7) valves[idx] = ((n - 500) % 2 == 0);
      end else if (n >= 600 && n <= 623) begin
        enables = group_mask(5'(n - 600));
      end
    endfunction

    function void jog(int sense);
      int d, np;
      logic lim;
      for (int i = 0; i < 24; i++) begin
        if (enables[i]) begin
          d = int'(step) * sense;
          if (dirs[i]) d = -d;
          np = int'(pos[i]) + d;
          lim = 0;
          if (np >= int'(min_pos) && np <= int'(max_pos)) pos[i] = 12'(np);
          else lim = 1;
          push(1, 5'(i), pos[i], lim, 0);
        end
      end
    endfunction

    function void note_key(logic [16:0] code);
      logic [15:0] key;
      int n, before_cnt;
      int weight[4];
      weight = '{1000, 100, 10, 1};
      key = code[15:0];
      n = 0;
      before_cnt = expected_results.size();
      if (key == KEY_TEST) begin
      end else if (key == KEY_FUNC) begin
        move_mode = !move_mode;
      end else if (move_mode) begin
        if (key == KEY_UP) jog(1);
        else if (key == KEY_DOWN) jog(-1);
        else if (key == KEY_REC)
          for (int i = 0; i < 24; i++) push(1, 5'(i), pos[i], 0, 0);
      end else if (!entry) begin
        if (key == KEY_RESET) clear_settings();
        else if (key == KEY_CMD) entry = 1;
      end else begin
        if (key == KEY_OK) begin
          for (int i = 0; i < 4; i++) begin
            if (digits[i] == DIGIT_EMPTY) break;
            n += int'(digits[i]) * weight[i];
          end
          run_number(n);
          for (int i = 0; i < 4; i++) digits[i] = DIGIT_EMPTY;
          entry = 0;
        end else if (key == KEY_BACK) begin
          for (int i = 0; i < 4; i++) digits[i] = DIGIT_EMPTY;
          entry = 0;
        end else if (key >= KEY_DIGIT0 && key <= KEY_DIGIT0 + 16'd9) begin
          for (int i = 0; i < 4; i++) begin
            if (digits[i] == DIGIT_EMPTY) begin
              digits[i] = 4'(key - KEY_DIGIT0);
              break;
            end
          end
        end
      end
      if (expected_results.size() == before_cnt) push(0, 0, 0, 0, 14'(n));
      expected_results[expected_results.size() - 1].last = 1;
    endfunction

    function void check_result(servo_result_t got);
      servo_result_t exp_r;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [16:0] ir_code_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  servo_result_t got;

  remote_keyed_servo_jog_controller_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .ir_code_i,
    .out_valid_o, .out_ready_i,
    .kind_o(got.kind), .channel_o(got.channel), .position_o(got.position),
    .at_limit_o(got.at_limit), .move_mode_o(got.move_mode),
    .entry_active_o(got.entry_active), .enable_mask_o(got.enable_mask),
    .direction_mask_o(got.direction_mask), .valve_mask_o(got.valve_mask),
    .command_number_o(got.command_number), .last_o(got.last)
  );

  always #10 clk_i = ~clk_i;

  jog_predictor predictor = new();
  int keys_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int phases_done = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) predictor.check_result(got);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) begin
        $display("FAILURE");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 0;
      end else if (phases_done != 2 && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send_key(input logic [16:0] code);
    int gap;
    gap = (phases_done == 2) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    ir_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    predictor.note_key(code);
    keys_sent++;
  endtask

  function automatic logic [16:0] with_toggle(logic [15:0] key);
    return {1'($urandom_range(0, 1)), key};
  endfunction

  task automatic send_number(input int n);
    int v;
    send_key(with_toggle(KEY_CMD));
    v = n;
    for (int i = 0; i < 4; i++) begin
      send_key(with_toggle(KEY_DIGIT0 + 16'((v / 1000) % 10)));
      v = (v % 1000) * 10;
    end
    send_key(with_toggle(KEY_OK));
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (predictor.expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    predictor.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_burst(input int count);
    int r, n;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        send_key({1'($urandom_range(0, 1)), 16'($urandom)});
      end else if (r < 4) begin
        send_key(with_toggle(KEY_FUNC));
      end else if (predictor.move_mode) begin
        case ($urandom_range(0, 5))
          0, 1: send_key(with_toggle(KEY_UP));
          2, 3: send_key(with_toggle(KEY_DOWN));
          4: send_key(with_toggle(KEY_REC));
          default: send_key(with_toggle(KEY_TEST));
        endcase
      end else if (r < 5) begin
        send_key(with_toggle(KEY_RESET));
      end else if (r < 7) begin
        send_key(with_toggle(KEY_CMD));
        repeat ($urandom_range(0, 5))
          send_key(with_toggle(KEY_DIGIT0 + 16'($urandom_range(0, 9))));
        send_key(with_toggle($urandom_range(0, 1) ? KEY_OK : KEY_BACK));
      end else begin
        case ($urandom_range(0, 3))
          0: n = $urandom_range(1, 96);
          1: n = $urandom_range(500, 513);
          2: n = $urandom_range(600, 623);
          default: n = $urandom_range(0, 9999);
        endcase
        send_number(n);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    write_reg(REG_HOME, 12'd280);

    // directed keys
    send_key(17'h00000);
    send_key(17'h1FFFF);
    send_key({1'b0, KEY_TEST});
    send_key({1'b1, KEY_TEST});
    send_key({1'b1, KEY_UP});
    send_number(1);
    send_number(12);
    send_number(96);
    send_number(600 + 3);
    send_number(500);
    send_number(513);
    send_key({1'b1, KEY_CMD});
    send_key({1'b0, KEY_DIGIT0 + 16'd1});
    send_key({1'b0, KEY_DIGIT0 + 16'd2});
    send_key({1'b1, KEY_OK});
    send_key({1'b1, KEY_CMD});
    send_key({1'b0, KEY_BACK});
    send_key({1'b0, KEY_FUNC});
    send_key({1'b0, KEY_UP});
    send_key({1'b1, KEY_DOWN});
    send_key({1'b0, KEY_REC});
    send_key({1'b1, KEY_FUNC});
    send_key({1'b0, KEY_RESET});
    send_key({1'b1, KEY_DOWN});
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_MIN, 12'd0);    write_reg(REG_MAX, 12'd4095);
                 write_reg(REG_STEP, 12'd255); end
        1: begin write_reg(REG_MIN, 12'd4095); write_reg(REG_MAX, 12'd0);
                 write_reg(REG_STEP, 12'd1); end
        2: begin write_reg(REG_MIN, 12'd100);  write_reg(REG_MAX, 12'd300);
                 write_reg(REG_STEP, 12'd0); end
        3: begin write_reg(REG_MIN, 12'd200);  write_reg(REG_MAX, 12'd360);
                 write_reg(REG_STEP, 12'd40); end
        default: begin write_reg(REG_MIN, 12'd95); write_reg(REG_MAX, 12'd460);
                 write_reg(REG_STEP, 12'd5); end
      endcase
      random_burst(25);
      drain();
      phases_done++;
    end

    $display("%0d keys sent over 5 limit/step settings, %0d results checked",
             keys_sent, predictor.results_seen);
    if (predictor.mismatches == 0 && predictor.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", predictor.mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
